>>> hw/rtl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// Types, codes and decode functions shared by the telemetry packet checker.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int unsigned OffsetW = 5;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SumW    = 16;
  localparam int unsigned PartsW  = 3;

  localparam logic [SumW-1:0]    CkMult     = 16'd44111;
  localparam logic [ByteW-1:0]   MarkerByte = 8'hFF;

  localparam logic [ByteW-1:0]   CodeLink     = 8'h01;
  localparam logic [ByteW-1:0]   CodeImu      = 8'h1F;
  localparam logic [ByteW-1:0]   CodeGps      = 8'h24;
  localparam logic [ByteW-1:0]   CodeDetector = 8'h56;
  localparam logic [ByteW-1:0]   CodeLight    = 8'h2B;
  localparam logic [ByteW-1:0]   CodeCalib    = 8'h46;

  localparam logic [OffsetW-1:0] OffKind      = 5'd0;
  localparam logic [OffsetW-1:0] OffPart      = 5'd2;
  localparam logic [OffsetW-1:0] OffSumLow    = 5'd30;
  localparam logic [OffsetW-1:0] OffLast      = 5'd31;
  localparam logic [OffsetW-1:0] OffPadFirst  = 5'd19;
  localparam logic [OffsetW-1:0] OffPadLast   = 5'd25;

  localparam logic [ByteW-1:0]   PartFirst    = 8'd1;
  localparam logic [ByteW-1:0]   PartLast     = 8'd3;
  localparam logic [PartsW-1:0]  PartsAll     = 3'b111;

  typedef enum logic [2:0] {
    KindUnknown  = 3'd0,
    KindLink     = 3'd1,
    KindImu      = 3'd2,
    KindGps      = 3'd3,
    KindDetector = 3'd4,
    KindLight    = 3'd5,
    KindCalib    = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusChecksum = 2'd1,
    StatusMarker   = 2'd2,
    StatusUnknown  = 2'd3
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             frame_start;
  } item_t;

  typedef struct packed {
    logic [OffsetW-1:0] byte_offset;
    logic [ByteW-1:0]   data_byte;
    logic               packet_end;
    status_e            packet_status;
    kind_e              packet_kind;
    logic [1:0]         calib_part;
    logic [PartsW-1:0]  calib_parts_seen;
    logic               calib_complete;
  } result_t;

  function automatic kind_e kind_index(logic [ByteW-1:0] code);
    kind_e k;
    unique case (code)
      CodeLink:     k = KindLink;
      CodeImu:      k = KindImu;
      CodeGps:      k = KindGps;
      CodeDetector: k = KindDetector;
      CodeLight:    k = KindLight;
      CodeCalib:    k = KindCalib;
      default:      k = KindUnknown;
    endcase
    return k;
  endfunction

  function automatic logic must_be_ff(kind_e kind, logic [OffsetW-1:0] off,
                                      logic [ByteW-1:0] part);
    logic pad;
    logic hdr;
    logic r;
    pad = (off >= OffPadFirst) && (off <= OffPadLast);
    hdr = (off == 5'd1) || (off == 5'd2);
    case (kind) inside
      KindImu, KindDetector: r = hdr;
      KindGps:               r = hdr || (off == OffPadLast);
      KindLight:             r = hdr || pad;
      KindCalib:             r = (off == 5'd1) || (off == 5'd27) || (off == 5'd28) ||
                                 (off == 5'd29) || (pad && (part == PartLast));
      default:               r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/tpc_in_stage.sv
// ----------------------------------------------------------------------------
// tpc_in_stage
// Input register; holds one byte transaction until the checker takes it.
// ----------------------------------------------------------------------------
module tpc_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tpc_pkg::item_t  item_i,
  input  logic            advance_i,
  output logic            valid_o,
  output tpc_pkg::item_t  item_o
);

  logic           valid_d, valid_q;
  tpc_pkg::item_t item_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> hw/rtl/tpc_check.sv
// ----------------------------------------------------------------------------
// tpc_check
// Packet state, running checksum, marker checks and end-of-packet verdict.
// ----------------------------------------------------------------------------
module tpc_check (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  tpc_pkg::item_t   item_i,
  output tpc_pkg::result_t result_o
);

  logic [tpc_pkg::OffsetW-1:0] position_d, position_q;
  logic [tpc_pkg::SumW-1:0]    running_sum_d, running_sum_q;
  logic [tpc_pkg::ByteW-1:0]   low_byte_hold_d, low_byte_hold_q;
  logic [tpc_pkg::ByteW-1:0]   kind_code_d, kind_code_q;
  logic [tpc_pkg::ByteW-1:0]   part_number_d, part_number_q;
  logic                        marker_fault_d, marker_fault_q;
  logic [tpc_pkg::ByteW-1:0]   stored_sum_low_d, stored_sum_low_q;
  logic [tpc_pkg::PartsW-1:0]  parts_received_d, parts_received_q;

  logic [tpc_pkg::OffsetW-1:0] off;
  logic [tpc_pkg::ByteW-1:0]   b;
  logic [tpc_pkg::SumW-1:0]    word;
  logic [tpc_pkg::SumW-1:0]    prod;
  logic [tpc_pkg::SumW-1:0]    sum_add;
  logic [tpc_pkg::SumW-1:0]    stored;
  logic                        part_ok;
  tpc_pkg::kind_e              kind;
  tpc_pkg::status_e            status;

  assign b    = item_i.rx_byte;
  assign off  = item_i.frame_start ? tpc_pkg::OffKind : position_q;
  assign word = {b, low_byte_hold_q};
  assign prod = word * tpc_pkg::CkMult;
  assign sum_add = running_sum_q + prod;
  assign stored  = {b, stored_sum_low_q};

  always_comb begin
    running_sum_d    = running_sum_q;
    low_byte_hold_d  = low_byte_hold_q;
    kind_code_d      = kind_code_q;
    part_number_d    = part_number_q;
    marker_fault_d   = marker_fault_q;
    stored_sum_low_d = stored_sum_low_q;
    parts_received_d = parts_received_q;
    status           = tpc_pkg::StatusOk;
    part_ok          = 1'b0;

    // new packet
    if (off == tpc_pkg::OffKind) begin
      running_sum_d  = '0;
      marker_fault_d = 1'b0;
      kind_code_d    = b;
      part_number_d  = '0;
    end
    if (off == tpc_pkg::OffPart) begin
      part_number_d = b;
    end

    // checksum over bytes 0 to 29
    if (off < tpc_pkg::OffSumLow) begin
      if (!off[0]) begin
        low_byte_hold_d = b;
      end else begin
        running_sum_d = sum_add ^ {8'h00, sum_add[15:8]};
      end
    end else if (off == tpc_pkg::OffSumLow) begin
      stored_sum_low_d = b;
    end

    kind = tpc_pkg::kind_index(kind_code_d);
    if (tpc_pkg::must_be_ff(kind, off, part_number_d) && (b != tpc_pkg::MarkerByte)) begin
      marker_fault_d = 1'b1;
    end

    // verdict
    if (off == tpc_pkg::OffLast) begin
      if (kind == tpc_pkg::KindUnknown) begin
        status = tpc_pkg::StatusUnknown;
      end else if (kind == tpc_pkg::KindLink) begin
        status = tpc_pkg::StatusOk;
      end else if (stored != running_sum_q) begin
        status = tpc_pkg::StatusChecksum;
      end else if (marker_fault_d) begin
        status = tpc_pkg::StatusMarker;
      end
      part_ok = (kind == tpc_pkg::KindCalib) && (status == tpc_pkg::StatusOk) &&
                (part_number_d >= tpc_pkg::PartFirst) &&
                (part_number_d <= tpc_pkg::PartLast);
      if (part_ok) begin
        parts_received_d = parts_received_q |
                           3'(3'b001 << (part_number_d[1:0] - 2'd1));
      end
    end
  end

  assign position_d = off + 5'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q       <= '0;
      running_sum_q    <= '0;
      low_byte_hold_q  <= '0;
      kind_code_q      <= '0;
      part_number_q    <= '0;
      marker_fault_q   <= 1'b0;
      stored_sum_low_q <= '0;
      parts_received_q <= '0;
    end else if (fire_i) begin
      position_q       <= position_d;
      running_sum_q    <= running_sum_d;
      low_byte_hold_q  <= low_byte_hold_d;
      kind_code_q      <= kind_code_d;
      part_number_q    <= part_number_d;
      marker_fault_q   <= marker_fault_d;
      stored_sum_low_q <= stored_sum_low_d;
      parts_received_q <= parts_received_d;
    end
  end

  always_comb begin
    result_o.byte_offset      = off;
    result_o.data_byte        = b;
    result_o.packet_end       = (off == tpc_pkg::OffLast);
    result_o.packet_status    = status;
    result_o.packet_kind      = (off == tpc_pkg::OffLast) ? kind : tpc_pkg::KindUnknown;
    result_o.calib_part       = part_ok ? part_number_d[1:0] : 2'd0;
    result_o.calib_parts_seen = parts_received_d;
    result_o.calib_complete   = (parts_received_d == tpc_pkg::PartsAll);
  end

endmodule

>>> hw/rtl/tpc_out_stage.sv
// ----------------------------------------------------------------------------
// tpc_out_stage
// Result register; holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module tpc_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  tpc_pkg::result_t result_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tpc_pkg::result_t result_o
);

  logic             valid_d, valid_q;
  tpc_pkg::result_t result_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

>>> hw/rtl/telemetry_packet_checker.sv
// ----------------------------------------------------------------------------
// telemetry_packet_checker
// Byte-serial checker for fixed 32-byte telemetry packets.
// ----------------------------------------------------------------------------
// usage
//   input channel: one packet byte per transaction (rx_byte_i), with
//   frame_start_i forcing the byte to offset 0 of a new packet
//   output channel: one result per input byte, echoing the byte and its
//   offset; on offset 31 packet_end_o is set and the verdict, kind and
//   calibration part are valid, otherwise those fields read zero
//   path: an accepted byte passes the input register, then the
//   checksum/marker logic into the result register
//   throughput: one byte per cycle while out_ready_i stays high; the
//   single 16x16 checksum multiply lies between the two registers
//   reset: offset, checksum, marker state and the calibration part mask
//   all clear; the first byte after reset is offset 0
//   stall: while the receiver holds out_ready_i low the result register
//   holds; the input register still takes one more byte, then in_ready_o
//   drops until the result is taken
// ----------------------------------------------------------------------------
module telemetry_packet_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_start_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [4:0] byte_offset_o,
  output logic [7:0] data_byte_o,
  output logic       packet_end_o,
  output logic [1:0] packet_status_o,
  output logic [2:0] packet_kind_o,
  output logic [1:0] calib_part_o,
  output logic [2:0] calib_parts_seen_o,
  output logic       calib_complete_o
);

  tpc_pkg::item_t   in_item;
  tpc_pkg::item_t   s1_item;
  tpc_pkg::result_t s1_result;
  tpc_pkg::result_t out_result;
  logic             s1_valid;
  logic             out_free;
  logic             advance;

  assign in_item.rx_byte     = rx_byte_i;
  assign in_item.frame_start = frame_start_i;
  assign advance             = s1_valid && out_free;

  tpc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  tpc_check u_check (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (s1_item),
    .result_o (s1_result)
  );

  tpc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (s1_result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign byte_offset_o      = out_result.byte_offset;
  assign data_byte_o        = out_result.data_byte;
  assign packet_end_o       = out_result.packet_end;
  assign packet_status_o    = out_result.packet_status;
  assign packet_kind_o      = out_result.packet_kind;
  assign calib_part_o       = out_result.calib_part;
  assign calib_parts_seen_o = out_result.calib_parts_seen;
  assign calib_complete_o   = out_result.calib_complete;

`ifndef SYNTHESIS
  // end flag tracks the last offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (packet_end_o == (byte_offset_o == tpc_pkg::OffLast)))
    else $error("packet_end does not match offset");

  // verdict fields are zero outside the last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !packet_end_o) |->
      (packet_status_o == tpc_pkg::StatusOk && packet_kind_o == tpc_pkg::KindUnknown &&
       calib_part_o == 2'd0))
    else $error("verdict fields set before packet end");

  // complete flag follows the part mask
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (calib_complete_o == (calib_parts_seen_o == tpc_pkg::PartsAll)))
    else $error("calib_complete does not match part mask");

  // both stages full and receiver stalled blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while pipeline is full");

  // an accepted calibration part is always recorded in the mask
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && calib_part_o != 2'd0) |->
      (calib_parts_seen_o[calib_part_o - 2'd1] && packet_kind_o == tpc_pkg::KindCalib))
    else $error("calibration part not recorded");
`endif

endmodule
